>>> rtl/core/gcit_pkg.sv
// ----------------------------------------------------------------------------
// gcit_pkg
// Shared constants, types and helpers of the glyph cell ink trim block.
// ----------------------------------------------------------------------------
package gcit_pkg;

    localparam int MAX_CELL      = 32;
    localparam int CELLS_PER_ROW = 16;
    localparam int CELL_W        = 6;
    localparam int ALPHA_W       = 8;
    localparam int CODE_W        = 8;
    localparam int BAND_W        = 4;
    localparam int CELL_X_W      = 4;
    localparam int INK_DEPTH     = CELLS_PER_ROW * MAX_CELL;
    localparam int COL_W         = $clog2(INK_DEPTH);
    localparam int RC_W          = $clog2(MAX_CELL);
    // ink store: one memory word per MAX_CELL columns
    localparam int WORD_W        = MAX_CELL;
    localparam int BIT_W         = $clog2(WORD_W);
    localparam int NUM_WORDS     = INK_DEPTH / WORD_W;
    localparam int WORD_IDX_W    = $clog2(NUM_WORDS);

    typedef logic [CELL_W-1:0]     cell_t;
    typedef logic [WORD_IDX_W-1:0] word_idx_t;
    typedef logic [WORD_W-1:0]     word_t;

    typedef struct packed {
        logic      clear;
        logic      wr_en;
        word_idx_t wr_word;
        logic [BIT_W-1:0] wr_bit;
    } ink_wr_t;

    typedef struct packed {
        logic              start;
        logic [BAND_W-1:0] band_row;
    } band_req_t;

    typedef struct packed {
        word_idx_t word_a;
        word_idx_t word_b;
    } ink_rd_t;

    // register value to effective cell size: 0 acts as 1, large values clip
    function automatic cell_t eff_cell(input cell_t raw);
        cell_t res;
        if (raw == '0) begin
            res = cell_t'(1);
        end else if (raw > cell_t'(MAX_CELL)) begin
            res = cell_t'(MAX_CELL);
        end else begin
            res = raw;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/gcit_ink_ram.sv
// ----------------------------------------------------------------------------
// gcit_ink_ram
// Column occupancy store: one word per group of columns, bit-level set,
// per-word valid flags cleared all at once at band start, two read ports.
// ----------------------------------------------------------------------------
module gcit_ink_ram (
    input  logic             aclk,
    input  logic             aresetn,
    input  gcit_pkg::ink_wr_t wr,
    input  gcit_pkg::ink_rd_t rd,
    output gcit_pkg::word_t  rd_data_a,
    output gcit_pkg::word_t  rd_data_b
);
    import gcit_pkg::*;

    word_t                mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] valid_reg;
    logic                 word_live;
    word_t                rd_a_reg;
    word_t                rd_b_reg;

    // a word untouched since the last band start counts as empty
    assign word_live = valid_reg[wr.wr_word] && !wr.clear;

    always_ff @(posedge aclk) begin
        if (wr.wr_en) begin
            if (word_live) begin
                mem[wr.wr_word][wr.wr_bit] <= 1'b1;
            end else begin
                mem[wr.wr_word] <= word_t'(1) << wr.wr_bit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (wr.clear) begin
                valid_reg <= '0;
            end
            if (wr.wr_en) begin
                valid_reg[wr.wr_word] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_a_reg <= valid_reg[rd.word_a] ? mem[rd.word_a] : '0;
        rd_b_reg <= valid_reg[rd.word_b] ? mem[rd.word_b] : '0;
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

>>> rtl/core/gcit_scan.sv
// ----------------------------------------------------------------------------
// gcit_scan
// Pixel intake: raster counters, ink writes into the store, band-end trigger.
// ----------------------------------------------------------------------------
module gcit_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gcit_pkg::ALPHA_W-1:0]  s_alpha,
    input  logic                          s_first_pixel,
    input  gcit_pkg::cell_t               cell_size,
    input  logic                          busy,
    output gcit_pkg::ink_wr_t             wr,
    output gcit_pkg::band_req_t           band
);
    import gcit_pkg::*;

    logic [COL_W-1:0]  pixel_column_reg, pixel_column_next;
    logic [RC_W-1:0]   row_in_cell_reg, row_in_cell_next;
    logic [BAND_W-1:0] cell_row_reg, cell_row_next;

    logic              xfer;
    logic [COL_W-1:0]  pc_cur;
    logic [RC_W-1:0]   rc_cur;
    logic [BAND_W-1:0] cr_cur;
    logic [COL_W:0]    row_width;
    logic [COL_W:0]    pc_inc;
    logic [RC_W:0]     rc_inc;
    logic              row_end;
    logic              band_end;

    assign s_ready = !busy;
    assign xfer    = s_valid && s_ready;

    // a new atlas mark restarts the counters before this pixel
    assign pc_cur = s_first_pixel ? '0 : pixel_column_reg;
    assign rc_cur = s_first_pixel ? '0 : row_in_cell_reg;
    assign cr_cur = s_first_pixel ? '0 : cell_row_reg;

    assign row_width = (COL_W+1)'(cell_size) * (COL_W+1)'(CELLS_PER_ROW);
    assign pc_inc    = {1'b0, pc_cur} + (COL_W+1)'(1);
    assign rc_inc    = {1'b0, rc_cur} + (RC_W+1)'(1);
    assign row_end   = pc_inc >= row_width;
    assign band_end  = row_end && (rc_inc >= (RC_W+1)'(cell_size));

    always_comb begin
        wr.clear   = xfer && (pc_cur == '0) && (rc_cur == '0);
        wr.wr_en   = xfer && (s_alpha != '0) && ({1'b0, pc_cur} < row_width);
        wr.wr_word = pc_cur[COL_W-1:BIT_W];
        wr.wr_bit  = pc_cur[BIT_W-1:0];
        band.start    = xfer && band_end;
        band.band_row = cr_cur;
    end

    always_comb begin
        pixel_column_next = pixel_column_reg;
        row_in_cell_next  = row_in_cell_reg;
        cell_row_next     = cell_row_reg;
        if (xfer) begin
            pixel_column_next = row_end ? '0 : pc_inc[COL_W-1:0];
            row_in_cell_next  = rc_cur;
            cell_row_next     = cr_cur;
            if (row_end) begin
                row_in_cell_next = band_end ? '0 : rc_inc[RC_W-1:0];
                if (band_end) begin
                    cell_row_next = cr_cur + BAND_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_column_reg <= '0;
            row_in_cell_reg  <= '0;
            cell_row_reg     <= '0;
        end else begin
            pixel_column_reg <= pixel_column_next;
            row_in_cell_reg  <= row_in_cell_next;
            cell_row_reg     <= cell_row_next;
        end
    end

endmodule

>>> rtl/core/gcit_extent.sv
// ----------------------------------------------------------------------------
// gcit_extent
// Band readout: per cell, fetch two store words, align the cell's columns,
// find first and last inked column, and hold the result until transferred.
// ----------------------------------------------------------------------------
module gcit_extent (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  gcit_pkg::cell_t              cell_size,
    input  gcit_pkg::band_req_t          band,
    output logic                         busy,
    output gcit_pkg::ink_rd_t            rd,
    input  gcit_pkg::word_t              rd_data_a,
    input  gcit_pkg::word_t              rd_data_b,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gcit_pkg::CODE_W-1:0]  m_glyph_code,
    output gcit_pkg::cell_t              m_left_blank,
    output gcit_pkg::cell_t              m_ink_width,
    output logic                         m_last
);
    import gcit_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ALIGN,
        ST_MEASURE,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [CELL_X_W-1:0]   cell_x_reg, cell_x_next;
    logic [COL_W-1:0]      base_reg, base_next;
    logic [BAND_W-1:0]     band_row_reg, band_row_next;
    word_t                 win_reg, win_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    cell_t                 lead_reg, lead_next;
    cell_t                 width_reg, width_next;
    logic                  last_reg, last_next;

    logic [2*WORD_W-1:0]   pair;
    logic [WORD_W:0]       mask_wide;
    word_t                 aligned;
    logic [BIT_W-1:0]      lo_idx;
    logic [BIT_W-1:0]      hi_idx;

    assign rd.word_a = base_reg[COL_W-1:BIT_W];
    assign rd.word_b = base_reg[COL_W-1:BIT_W] + WORD_IDX_W'(1);

    assign pair      = {rd_data_b, rd_data_a} >> base_reg[BIT_W-1:0];
    assign mask_wide = ((WORD_W+1)'(1) << cell_size) - (WORD_W+1)'(1);
    assign aligned   = pair[WORD_W-1:0] & mask_wide[WORD_W-1:0];

    // lowest and highest inked column of the aligned cell
    always_comb begin
        lo_idx = '0;
        hi_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (win_reg[i]) begin
                lo_idx = BIT_W'(i);
            end
        end
        for (int i = 0; i < WORD_W; i++) begin
            if (win_reg[i]) begin
                hi_idx = BIT_W'(i);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        cell_x_next   = cell_x_reg;
        base_next     = base_reg;
        band_row_next = band_row_reg;
        win_next      = win_reg;
        m_valid_next  = m_valid_reg;
        code_next     = code_reg;
        lead_next     = lead_reg;
        width_next    = width_reg;
        last_next     = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (band.start) begin
                    cell_x_next   = '0;
                    base_next     = '0;
                    band_row_next = band.band_row;
                    state_next    = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_ALIGN;
            end
            ST_ALIGN: begin
                win_next   = aligned;
                state_next = ST_MEASURE;
            end
            ST_MEASURE: begin
                code_next = {band_row_reg, cell_x_reg};
                last_next = (cell_x_reg == CELL_X_W'(CELLS_PER_ROW - 1));
                if (win_reg == '0) begin
                    lead_next  = cell_size;
                    width_next = '0;
                end else begin
                    lead_next  = cell_t'(lo_idx);
                    width_next = cell_t'(hi_idx) - cell_t'(lo_idx) + cell_t'(1);
                end
                m_valid_next = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        cell_x_next = cell_x_reg + CELL_X_W'(1);
                        base_next   = base_reg + COL_W'(cell_size);
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cell_x_reg   <= cell_x_next;
        base_reg     <= base_next;
        band_row_reg <= band_row_next;
        win_reg      <= win_next;
        code_reg     <= code_next;
        lead_reg     <= lead_next;
        width_reg    <= width_next;
        last_reg     <= last_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_glyph_code = code_reg;
    assign m_left_blank = lead_reg;
    assign m_ink_width  = width_reg;
    assign m_last       = last_reg;

endmodule

>>> rtl/core/glyph_cell_ink_trim.sv
// Glyph ink extent for a 16 x 16 cell font atlas. Pixels are taken one per
// cycle in raster order. After the last pixel of a band of cells the input
// stalls while the 16 results of that band are produced; each result passes
// four steps (store read, column alignment, first/last ink search, output
// register), and the stall lasts longer while m_ready is low.
// Column occupancy lives in a 16-word by 32-bit store with one valid flag per
// word; the flags are all cleared together at band start, so there is no
// clearing pass after reset. cell_size may only be written while idle.
// ----------------------------------------------------------------------------
// glyph_cell_ink_trim
// Top level: configuration register, pixel intake, ink store, band readout.
// ----------------------------------------------------------------------------
module glyph_cell_ink_trim (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [gcit_pkg::CELL_W-1:0]  cfg_cell_size,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [gcit_pkg::ALPHA_W-1:0] s_alpha,
    input  logic                         s_first_pixel,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gcit_pkg::CODE_W-1:0]  m_glyph_code,
    output logic [gcit_pkg::CELL_W-1:0]  m_left_blank,
    output logic [gcit_pkg::CELL_W-1:0]  m_ink_width,
    output logic                         m_last
);
    import gcit_pkg::*;

    cell_t     cell_size_reg;
    cell_t     cell_eff;
    ink_wr_t   wr;
    ink_rd_t   rd;
    band_req_t band;
    logic      busy;
    word_t     rd_data_a;
    word_t     rd_data_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_size_reg <= cell_t'(16);
        end else if (cfg_valid && cfg_ready) begin
            cell_size_reg <= cfg_cell_size;
        end
    end

    assign cell_eff = eff_cell(cell_size_reg);

    gcit_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_alpha       (s_alpha),
        .s_first_pixel (s_first_pixel),
        .cell_size     (cell_eff),
        .busy          (busy),
        .wr            (wr),
        .band          (band)
    );

    gcit_ink_ram u_ram (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .rd        (rd),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    gcit_extent u_extent (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cell_size    (cell_eff),
        .band         (band),
        .busy         (busy),
        .rd           (rd),
        .rd_data_a    (rd_data_a),
        .rd_data_b    (rd_data_b),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_glyph_code (m_glyph_code),
        .m_left_blank (m_left_blank),
        .m_ink_width  (m_ink_width),
        .m_last       (m_last)
    );

endmodule

>>> rtl/core/gcit_checker.sv
// ----------------------------------------------------------------------------
// gcit_checker
// Port-level checks of the glyph cell ink trim block, bound to the top level.
// ----------------------------------------------------------------------------
module gcit_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [gcit_pkg::CODE_W-1:0]  m_glyph_code,
    input logic [gcit_pkg::CELL_W-1:0]  m_left_blank,
    input logic [gcit_pkg::CELL_W-1:0]  m_ink_width,
    input logic                         m_last
);
    import gcit_pkg::*;

    // results go out only while pixel intake is stalled
    a_result_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("result pending while input ready");

    // left blank plus ink width never exceeds the largest cell size
    a_extent_in_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (({1'b0, m_left_blank} + {1'b0, m_ink_width})
                     <= (CELL_W+1)'(MAX_CELL)))
        else $error("ink extent exceeds cell");

    // the band's final result ends the burst
    a_last_ends_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> !m_valid)
        else $error("result after last of band");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_glyph_code)
                                   && $stable(m_left_blank) && $stable(m_ink_width)))
        else $error("stalled result changed");

endmodule

bind glyph_cell_ink_trim gcit_checker u_gcit_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_glyph_code (m_glyph_code),
    .m_left_blank (m_left_blank),
    .m_ink_width  (m_ink_width),
    .m_last       (m_last)
);

>>> test/glyph_cell_ink_trim_test.sv
// ----------------------------------------------------------------------------
// glyph_cell_ink_trim_test
// Streams font atlas pixels into glyph_cell_ink_trim and checks every glyph
// extent against a cycle-free predictor of the band logic. Covers the reset
// cell size, minimum, zero, maximum and clipped sizes, size changes mid-atlas,
// new-atlas marks, band counter wrap, and long output stalls under gapless input.
// ----------------------------------------------------------------------------
module glyph_cell_ink_trim_test;
    import gcit_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 80;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_e;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic [CELL_W-1:0] lead;
        logic [CELL_W-1:0] width;
        logic              last;
    } glyph_extent_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [CELL_W-1:0]   cfg_cell_size = '0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [ALPHA_W-1:0]  s_alpha       = '0;
    logic                s_first_pixel = 1'b0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [CODE_W-1:0]   m_glyph_code;
    logic [CELL_W-1:0]   m_left_blank;
    logic [CELL_W-1:0]   m_ink_width;
    logic                m_last;

    // predictor state
    bit [INK_DEPTH-1:0]  ink_cols   = '0;
    int unsigned         pred_col   = 0;
    int unsigned         pred_line  = 0;
    int unsigned         pred_band  = 0;
    cell_t               cfg_side   = cell_t'(16);
    glyph_extent_t       extents_due[$];

    int          cycles          = 0;
    int          errors          = 0;
    int          items_sent      = 0;
    int          results_checked = 0;
    int          cfg_writes      = 0;
    int          bands_done      = 0;
    bit          gaps_on         = 1'b1;
    int          burst_left      = 0;
    rx_style_e   rx_mode         = RX_ALWAYS;
    int          hold_req        = 0;
    int          hold_left       = 0;
    int          rx_phase        = 0;

    glyph_cell_ink_trim dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_cell_size (cfg_cell_size),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_alpha       (s_alpha),
        .s_first_pixel (s_first_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_glyph_code  (m_glyph_code),
        .m_left_blank  (m_left_blank),
        .m_ink_width   (m_ink_width),
        .m_last        (m_last)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d extents pending", cycles,
                     extents_due.size());
            $display("glyph_cell_ink_trim_test NOT OK");
            $finish;
        end
    end

    // receiver: own stall pattern, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                default:   m_ready <= ((rx_phase % 9) >= 3);
            endcase
        end
        rx_phase++;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("[cycle %0d] mismatch: %s", cycles, what);
    endtask

    always @(posedge aclk) begin
        glyph_extent_t e;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (extents_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result code %0d", m_glyph_code));
            end else begin
                e = extents_due.pop_front();
                if (m_glyph_code !== e.code)
                    report_mismatch($sformatf("glyph_code %0d, want %0d",
                                              m_glyph_code, e.code));
                if (m_left_blank !== e.lead)
                    report_mismatch($sformatf("code %0d left_blank %0d, want %0d",
                                              e.code, m_left_blank, e.lead));
                if (m_ink_width !== e.width)
                    report_mismatch($sformatf("code %0d ink_width %0d, want %0d",
                                              e.code, m_ink_width, e.width));
                if (m_last !== e.last)
                    report_mismatch($sformatf("code %0d last %0b, want %0b",
                                              e.code, m_last, e.last));
            end
        end
    end

    // ---------------- predictor ----------------

    function automatic int unsigned active_side();
        if (cfg_side == '0) return 1;
        if (cfg_side > MAX_CELL) return MAX_CELL;
        return cfg_side;
    endfunction

    function automatic bit col_inked(input int unsigned c);
        return (c < INK_DEPTH) && ink_cols[c];
    endfunction

    task automatic track_pixel(input logic [ALPHA_W-1:0] a, input logic fp);
        int unsigned   side;
        int unsigned   row_w;
        int unsigned   base;
        int unsigned   lead;
        int unsigned   trail;
        int unsigned   ink_w;
        glyph_extent_t e;
        side  = active_side();
        row_w = side * CELLS_PER_ROW;
        if (fp) begin
            pred_col  = 0;
            pred_line = 0;
            pred_band = 0;
        end
        if (pred_col == 0 && pred_line == 0) ink_cols = '0;
        // columns past the row width (after a size shrink) record nothing
        if (a != '0 && pred_col < row_w && pred_col < INK_DEPTH) ink_cols[pred_col] = 1'b1;
        pred_col++;
        if (pred_col >= row_w) begin
            pred_col = 0;
            pred_line++;
            if (pred_line >= side) begin
                pred_line = 0;
                for (int x = 0; x < CELLS_PER_ROW; x++) begin
                    base  = x * side;
                    lead  = 0;
                    trail = 0;
                    ink_w = 0;
                    while (lead < side && !col_inked(base + lead)) lead++;
                    if (lead < side) begin
                        while (trail < side && !col_inked(base + side - 1 - trail)) trail++;
                        ink_w = side - lead - trail;
                    end
                    e.code  = CODE_W'((pred_band << BAND_W) + x);
                    e.lead  = CELL_W'(lead);
                    e.width = CELL_W'(ink_w);
                    e.last  = (x == CELLS_PER_ROW - 1);
                    extents_due.push_back(e);
                end
                pred_band = (pred_band + 1) & 15;
                bands_done++;
            end
        end
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic logic [ALPHA_W-1:0] ink_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h01;
            1:       return 8'hFF;
            default: return ALPHA_W'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [ALPHA_W-1:0] sparse_alpha();
        return ($urandom_range(0, 3) == 0) ? ink_byte() : '0;
    endfunction

    // per cell: empty, fully inked, or a random span with random interior
    function automatic bit [INK_DEPTH-1:0] random_mask(input int unsigned side);
        bit [INK_DEPTH-1:0] m;
        int unsigned        kind;
        int unsigned        lo;
        int unsigned        hi;
        m = '0;
        for (int x = 0; x < CELLS_PER_ROW; x++) begin
            kind = $urandom_range(0, 5);
            if (kind == 0) continue;
            lo = (kind == 1) ? 0 : $urandom_range(0, side - 1);
            hi = (kind == 1) ? side - 1 : $urandom_range(lo, side - 1);
            for (int c = lo; c <= hi; c++)
                m[x * side + c] = (c == lo || c == hi || kind == 1) ? 1'b1
                                                                    : 1'($urandom_range(0, 1));
        end
        return m;
    endfunction

    task automatic send_pixel(input logic [ALPHA_W-1:0] a, input logic fp);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_valid       <= 1'b1;
        s_alpha       <= a;
        s_first_pixel <= fp;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        track_pixel(a, fp);
    endtask

    // one band; each masked column gets ink in exactly one pixel row
    task automatic send_band(input int unsigned side, input bit [INK_DEPTH-1:0] mask,
                             input bit new_atlas);
        logic [ALPHA_W-1:0] a;
        for (int r = 0; r < side; r++) begin
            for (int c = 0; c < CELLS_PER_ROW * side; c++) begin
                a = (mask[c] && ((r + c) % side == 0)) ? ink_byte() : '0;
                send_pixel(a, new_atlas && r == 0 && c == 0);
            end
        end
    endtask

    task automatic send_noise(input int n, input bit first_is_new);
        for (int i = 0; i < n; i++) send_pixel(sparse_alpha(), first_is_new && i == 0);
    endtask

    task automatic run_to_band_end();
        int b;
        b = bands_done;
        while (bands_done == b) send_pixel(sparse_alpha(), 1'b0);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (extents_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_cell_size(input cell_t v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid     <= 1'b1;
        cfg_cell_size <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_side = v;
        cfg_writes++;
    endtask

    // ---------------- tests ----------------

    // mark on the first pixel after reset, then again mid-band; the second
    // one restarts the counters and drops the ink taken so far
    task automatic test_new_atlas_mark();
        rx_mode = RX_ALWAYS;
        gaps_on = 1'b1;
        send_noise(5, 1'b1);
        send_pixel(ink_byte(), 1'b1);
    endtask

    // partial row at the reset size, then a shrink ends the band early;
    // the pixel past the new row width records nothing
    task automatic test_default_size();
        rx_mode = RX_RANDOM;
        send_noise(17, 1'b0);
        write_cell_size(cell_t'(1));
        send_pixel(ink_byte(), 1'b0);
        drain_results();
    endtask

    task automatic test_side_extremes();
        rx_mode = RX_PATTERN;
        send_band(1, '0, 1'b0);
        // zero acts as one
        write_cell_size(cell_t'(0));
        send_band(1, '1, 1'b0);
        // largest size, then a value above it that clips
        write_cell_size(cell_t'(MAX_CELL));
        send_noise(3, 1'b0);
        write_cell_size(cell_t'(63));
        send_noise(3, 1'b0);
    endtask

    task automatic test_size_change_mid_atlas();
        rx_mode = RX_RANDOM;
        // shrink with the row counter already past the new limit
        write_cell_size(cell_t'(2));
        send_noise(27, 1'b0);
        write_cell_size(cell_t'(1));
        run_to_band_end();
        drain_results();
    endtask

    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        rx_mode = RX_ALWAYS;
        hold_req = 400;
        for (int b = 0; b < 3; b++) send_band(1, random_mask(1), 1'b0);
        drain_results();
        rx_mode = RX_RANDOM;
        gaps_on = 1'b1;
        send_band(1, random_mask(1), 1'b0);
        drain_results();
    endtask

    // run through the sixteenth band, then one more after the counter wraps
    task automatic test_band_wrap();
        rx_mode = RX_PATTERN;
        while (pred_band != 0) send_band(1, random_mask(1), 1'b0);
        send_band(1, random_mask(1), 1'b0);
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_new_atlas_mark();
        test_default_size();
        test_side_extremes();
        test_size_change_mid_atlas();
        test_output_backpressure();
        test_band_wrap();
        drain_results();
        repeat (SETTLE_CYCLES + 20) @(posedge aclk);
        $display("run: %0d pixels, %0d glyph extents checked, %0d cell_size writes",
                 items_sent, results_checked, cfg_writes);
        $display("sizes 0, 1, 16, 32 and 63, mid-atlas shrinks, atlas restarts, band wrap");
        if (errors == 0) begin
            $display("glyph_cell_ink_trim_test OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("glyph_cell_ink_trim_test NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/gcit_pkg.sv
rtl/core/gcit_ink_ram.sv
rtl/core/gcit_scan.sv
rtl/core/gcit_extent.sv
rtl/core/glyph_cell_ink_trim.sv
rtl/core/gcit_checker.sv
test/glyph_cell_ink_trim_test.sv
